FILE: rtl/swarq_pkg.sv
package swarq_pkg;

	// Item command codes
	typedef enum logic [1:0] {
		CMD_SEND      = 2'd0,
		CMD_REPLY     = 2'd1,
		CMD_TICK      = 2'd2,
		CMD_CLEAR_SEQ = 2'd3
	} cmd_t;

	// Result event codes
	typedef enum logic [2:0] {
		EV_TX_NEW   = 3'd0,
		EV_RETX     = 3'd1,
		EV_DELIVER  = 3'd2,
		EV_GAVE_UP  = 3'd3,
		EV_REJECTED = 3'd4
	} event_t;

	// Register indexes (paddr[2])
	typedef enum logic {
		REG_TIMEOUT = 1'b0,
		REG_RETRY   = 1'b1
	} reg_idx_t;

	localparam int unsigned FLAG_W   = 7;
	localparam int unsigned WORD_W   = 16;
	localparam int unsigned SUM_W    = 20;  // ten 16-bit words fit in 20 bits
	localparam int unsigned RETRY_W  = 8;
	localparam int unsigned ADDR_W   = 3;
	localparam int unsigned DATA_W   = 32;

	localparam int unsigned INUSE_BIT = 0;
	localparam int unsigned NACK_BIT  = 6;

	localparam logic [WORD_W-1:0]  TIMEOUT_RESET = 16'd1000;
	localparam logic [RETRY_W-1:0] RETRY_RESET   = 8'd5;

endpackage

FILE: rtl/stop_wait_arq_sender_unit.sv
// Stop-and-wait ARQ sender: a send item stamps the alternating sequence bit, forces the
// in-use flag and yields the header checksum; replies (ACK/NACK) and tick items drive
// retransmission, delivery and give-up. Each item passes an input register, where the
// header words other than the sequence bit are summed, and a result register, where the
// sequence bit is added, the sum folded and complemented and the protocol state updated.
// One item is accepted every cycle unless in_stall is high; the result register takes the
// result when its item leaves the input register, and a stalled result register holds the
// input register, which stalls the input. An item produces zero or one result. Registers:
// timeout_ticks at 0x0, retry_limit at 0x4; write them only while no packet is pending.
module stop_wait_arq_sender_unit #(
	parameter int unsigned TICK_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// configuration port
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [swarq_pkg::ADDR_W-1:0]           paddr,
	input  logic [swarq_pkg::DATA_W-1:0]           pwdata,
	output logic [swarq_pkg::DATA_W-1:0]           prdata,
	output logic                                   pready,
	// input channel
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [1:0]                             command,
	input  logic [31:0]                            src_address,
	input  logic [31:0]                            dst_address,
	input  logic [15:0]                            src_port,
	input  logic [15:0]                            dst_port,
	input  logic [15:0]                            ack_field,
	input  logic [6:0]                             flags_in,
	input  logic [15:0]                            packet_count,
	input  logic [6:0]                             rx_flags,
	input  logic [15:0]                            rx_ack,
	// result channel
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [2:0]                             event_kind,
	output logic                                   seq_bit,
	output logic [6:0]                             tx_flags,
	output logic [15:0]                            header_checksum,
	output logic [7:0]                             retries_used
);

	localparam int unsigned SUM_W   = swarq_pkg::SUM_W;
	localparam int unsigned WORD_W  = swarq_pkg::WORD_W;
	localparam int unsigned FLAG_W  = swarq_pkg::FLAG_W;
	localparam int unsigned RETRY_W = swarq_pkg::RETRY_W;
	localparam int unsigned CMP_W   = (TICK_BITS > WORD_W) ? TICK_BITS : WORD_W;

	// configuration registers
	logic [WORD_W-1:0]  timeout_q;
	logic [RETRY_W-1:0] limit_q;
	logic               cfg_wr;

	// input stage
	logic                   valid_s1;
	swarq_pkg::cmd_t        cmd_s1;
	logic [SUM_W-1:0]       psum_s1;
	logic [FLAG_W-1:0]      flags_s1;
	logic [FLAG_W-1:0]      rx_flags_s1;
	logic [WORD_W-1:0]      rx_ack_s1;
	logic [SUM_W-1:0]       psum_c;
	logic [FLAG_W-1:0]      flags_c;

	// protocol state
	logic                   awaiting_q;
	logic                   next_seq_q;
	logic                   pend_seq_q;
	logic [FLAG_W-1:0]      pend_flags_q;
	logic [WORD_W-1:0]      pend_cks_q;
	logic [TICK_BITS-1:0]   elapsed_q;
	logic [RETRY_W-1:0]     retry_q;

	logic                   awaiting_d;
	logic                   next_seq_d;
	logic                   pend_seq_d;
	logic [FLAG_W-1:0]      pend_flags_d;
	logic [WORD_W-1:0]      pend_cks_d;
	logic [TICK_BITS-1:0]   elapsed_d;
	logic [RETRY_W-1:0]     retry_d;

	// result decision
	logic                   emit_c;
	swarq_pkg::event_t      kind_c;
	logic                   advance;
	logic                   fire;

	// checksum fold and tick compare
	logic [SUM_W-1:0]       sum_full;
	logic [WORD_W:0]        fold1;
	logic [WORD_W-1:0]      fold2;
	logic [TICK_BITS-1:0]   elapsed_inc;
	logic                   timed_out;
	logic                   nack_c;
	logic                   ack_c;

	// result register
	logic                   out_valid_q;
	swarq_pkg::event_t      kind_q;
	logic                   seq_q;
	logic [FLAG_W-1:0]      tx_flags_q;
	logic [WORD_W-1:0]      cks_q;
	logic [RETRY_W-1:0]     retries_q;

	// ---------------------------------------------------------------- config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= swarq_pkg::TIMEOUT_RESET;
			limit_q   <= swarq_pkg::RETRY_RESET;
		end else if (cfg_wr) begin
			case (swarq_pkg::reg_idx_t'(paddr[2]))
				swarq_pkg::REG_TIMEOUT: timeout_q <= pwdata[WORD_W-1:0];
				swarq_pkg::REG_RETRY:   limit_q   <= pwdata[RETRY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (swarq_pkg::reg_idx_t'(paddr[2]))
			swarq_pkg::REG_TIMEOUT: prdata = {{(swarq_pkg::DATA_W-WORD_W){1'b0}}, timeout_q};
			swarq_pkg::REG_RETRY:   prdata = {{(swarq_pkg::DATA_W-RETRY_W){1'b0}}, limit_q};
			default:                prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- handshake
	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// ---------------------------------------------------------------- input stage
	// Sum the nine header words that do not depend on the sequence bit
	assign flags_c = flags_in | FLAG_W'(1 << swarq_pkg::INUSE_BIT);
	assign psum_c  = SUM_W'(src_address[15:0]) + SUM_W'(src_address[31:16])
		+ SUM_W'(dst_address[15:0]) + SUM_W'(dst_address[31:16])
		+ SUM_W'(src_port) + SUM_W'(dst_port) + SUM_W'(ack_field)
		+ SUM_W'(flags_c) + SUM_W'(packet_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Load payload on acceptance, hold while stalled
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1      <= swarq_pkg::cmd_t'(command);
			psum_s1     <= psum_c;
			flags_s1    <= flags_c;
			rx_flags_s1 <= rx_flags;
			rx_ack_s1   <= rx_ack;
		end
	end

	// ---------------------------------------------------------------- checksum
	// Add the sequence bit, fold twice with end-around carry, complement
	assign sum_full = psum_s1 + SUM_W'(next_seq_q);
	assign fold1    = (WORD_W+1)'(sum_full[WORD_W-1:0]) + (WORD_W+1)'(sum_full[SUM_W-1:WORD_W]);
	assign fold2    = fold1[WORD_W-1:0] + WORD_W'(fold1[WORD_W]);

	// ---------------------------------------------------------------- tick and reply
	assign elapsed_inc = (elapsed_q == {TICK_BITS{1'b1}}) ? elapsed_q : elapsed_q + 1'b1;
	assign timed_out   = CMP_W'(elapsed_inc) >= CMP_W'(timeout_q);
	assign nack_c      = rx_flags_s1[swarq_pkg::NACK_BIT] && rx_flags_s1[swarq_pkg::INUSE_BIT];
	assign ack_c       = rx_flags_s1[swarq_pkg::INUSE_BIT]
		&& (rx_ack_s1 == WORD_W'(pend_seq_q));

	// ---------------------------------------------------------------- protocol step
	always_comb begin
		awaiting_d   = awaiting_q;
		next_seq_d   = next_seq_q;
		pend_seq_d   = pend_seq_q;
		pend_flags_d = pend_flags_q;
		pend_cks_d   = pend_cks_q;
		elapsed_d    = elapsed_q;
		retry_d      = retry_q;
		emit_c       = 1'b0;
		kind_c       = swarq_pkg::EV_TX_NEW;
		case (cmd_s1)
			swarq_pkg::CMD_SEND: begin
				emit_c = 1'b1;
				if (awaiting_q) begin
					kind_c = swarq_pkg::EV_REJECTED;
				end else begin
					kind_c       = swarq_pkg::EV_TX_NEW;
					pend_seq_d   = next_seq_q;
					next_seq_d   = !next_seq_q;
					pend_flags_d = flags_s1;
					pend_cks_d   = ~fold2;
					elapsed_d    = '0;
					retry_d      = '0;
					awaiting_d   = 1'b1;
				end
			end
			swarq_pkg::CMD_REPLY: begin
				if (awaiting_q && nack_c) begin
					emit_c    = 1'b1;
					kind_c    = swarq_pkg::EV_RETX;
					elapsed_d = '0;
				end else if (awaiting_q && ack_c) begin
					emit_c     = 1'b1;
					kind_c     = swarq_pkg::EV_DELIVER;
					awaiting_d = 1'b0;
				end
			end
			swarq_pkg::CMD_TICK: begin
				if (awaiting_q) begin
					elapsed_d = elapsed_inc;
					if (timed_out) begin
						emit_c = 1'b1;
						if (retry_q >= limit_q) begin
							kind_c     = swarq_pkg::EV_GAVE_UP;
							awaiting_d = 1'b0;
						end else begin
							kind_c    = swarq_pkg::EV_RETX;
							retry_d   = retry_q + 1'b1;
							elapsed_d = '0;
						end
					end
				end
			end
			swarq_pkg::CMD_CLEAR_SEQ: begin
				next_seq_d = 1'b0;
			end
			default: ;
		endcase
	end

	// Advance protocol state when the item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q   <= 1'b0;
			next_seq_q   <= 1'b0;
			pend_seq_q   <= 1'b0;
			pend_flags_q <= '0;
			pend_cks_q   <= '0;
			elapsed_q    <= '0;
			retry_q      <= '0;
		end else if (fire) begin
			awaiting_q   <= awaiting_d;
			next_seq_q   <= next_seq_d;
			pend_seq_q   <= pend_seq_d;
			pend_flags_q <= pend_flags_d;
			pend_cks_q   <= pend_cks_d;
			elapsed_q    <= elapsed_d;
			retry_q      <= retry_d;
		end
	end

	// ---------------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && emit_c;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit_c) begin
			kind_q     <= kind_c;
			seq_q      <= pend_seq_d;
			tx_flags_q <= pend_flags_d;
			cks_q      <= pend_cks_d;
			retries_q  <= retry_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign event_kind      = kind_q;
	assign seq_bit         = seq_q;
	assign tx_flags        = tx_flags_q;
	assign header_checksum = cks_q;
	assign retries_used    = retries_q;

	// ---------------------------------------------------------------- assertions
	// A new transmission leaves a pending packet with a fresh retry count
	a_tx_new_pending: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit_c && kind_c == swarq_pkg::EV_TX_NEW
		|=> awaiting_q && retry_q == '0 && next_seq_q != pend_seq_q)
		else $error("new transmission did not set up pending packet");

	// Delivery or give-up returns to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit_c && (kind_c == swarq_pkg::EV_DELIVER || kind_c == swarq_pkg::EV_GAVE_UP)
		|=> !awaiting_q)
		else $error("block still busy after completing a packet");

	// A stalled input stage keeps its item
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(cmd_s1) && $stable(psum_s1))
		else $error("input stage lost an item under stall");

	// A reject only happens while a packet is pending, and changes nothing
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit_c && kind_c == swarq_pkg::EV_REJECTED
		|=> awaiting_q && $stable(pend_cks_q) && $stable(retry_q))
		else $error("rejected send altered the pending packet");

endmodule

FILE: verif/stop_wait_arq_sender_unit_tb.sv
`timescale 1ns / 1ps

module stop_wait_arq_sender_unit_tb;

	localparam int TICK_BITS    = 16;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;

	// One input item and one result item as the ports carry them
	typedef struct {
		swarq_pkg::cmd_t cmd;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [15:0] ack_no;
		logic [6:0]  flags;
		logic [15:0] pkt_count;
		logic [6:0]  reply_flags;
		logic [15:0] reply_ack;
	} arq_item_t;

	typedef struct {
		swarq_pkg::event_t kind;
		logic        seq;
		logic [6:0]  flags;
		logic [15:0] csum;
		logic [7:0]  retries;
	} arq_event_rec_t;

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        psel         = 1'b0;
	logic        penable      = 1'b0;
	logic        pwrite       = 1'b0;
	logic [swarq_pkg::ADDR_W-1:0] paddr  = '0;
	logic [swarq_pkg::DATA_W-1:0] pwdata = '0;
	logic [swarq_pkg::DATA_W-1:0] prdata;
	logic        pready;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic [1:0]  command      = swarq_pkg::CMD_TICK;
	logic [31:0] src_address  = '0;
	logic [31:0] dst_address  = '0;
	logic [15:0] src_port     = '0;
	logic [15:0] dst_port     = '0;
	logic [15:0] ack_field    = '0;
	logic [6:0]  flags_in     = '0;
	logic [15:0] packet_count = '0;
	logic [6:0]  rx_flags     = '0;
	logic [15:0] rx_ack       = '0;
	logic        out_valid;
	logic        out_stall    = 1'b0;
	logic [2:0]  event_kind;
	logic        seq_bit;
	logic [6:0]  tx_flags;
	logic [15:0] header_checksum;
	logic [7:0]  retries_used;

	// Shadow of the sender: configuration and protocol state
	logic [15:0]          tmo = swarq_pkg::TIMEOUT_RESET;
	logic [7:0]           lim = swarq_pkg::RETRY_RESET;
	bit                   pend;
	logic                 nxt_seq;
	logic                 pkt_seq;
	logic [6:0]           pkt_flags;
	logic [15:0]          pkt_csum;
	logic [TICK_BITS-1:0] tick_cnt;
	logic [7:0]           retry_cnt;

	arq_event_rec_t predicted_events[$];
	arq_event_rec_t want_ev;
	int mismatches;
	int live_items;
	int quiet_cycles;
	int sender_idle_pct;
	int stall_pct;

	stop_wait_arq_sender_unit #(.TICK_BITS(TICK_BITS)) u_top (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void flag_error(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endfunction

	// Ones' complement header checksum with end-around carry
	function automatic logic [15:0] hdr_checksum(arq_item_t it, logic seq, logic [6:0] fl);
		logic [31:0] acc;
		acc = 32'(it.src_addr[15:0]) + 32'(it.src_addr[31:16])
			+ 32'(it.dst_addr[15:0]) + 32'(it.dst_addr[31:16])
			+ 32'(it.sport) + 32'(it.dport) + 32'(seq) + 32'(it.ack_no)
			+ 32'(fl) + 32'(it.pkt_count);
		while (acc[31:16] != 16'd0)
			acc = {16'd0, acc[31:16]} + {16'd0, acc[15:0]};
		return ~acc[15:0];
	endfunction

	// Advance the shadow state by one item; return 1 when the item yields a result
	function automatic bit arq_advance(input arq_item_t it, output arq_event_rec_t res);
		bit                fire;
		swarq_pkg::event_t kind;
		fire = 1'b0;
		kind = swarq_pkg::EV_TX_NEW;
		case (it.cmd)
			swarq_pkg::CMD_SEND: begin
				fire = 1'b1;
				if (pend) begin
					kind = swarq_pkg::EV_REJECTED;
				end else begin
					pkt_seq   = nxt_seq;
					nxt_seq   = ~nxt_seq;
					pkt_flags = it.flags | 7'h01;
					pkt_csum  = hdr_checksum(it, pkt_seq, pkt_flags);
					tick_cnt  = '0;
					retry_cnt = '0;
					pend      = 1'b1;
					kind      = swarq_pkg::EV_TX_NEW;
				end
			end
			swarq_pkg::CMD_REPLY: begin
				if (pend) begin
					if (it.reply_flags[swarq_pkg::NACK_BIT]
							&& it.reply_flags[swarq_pkg::INUSE_BIT]) begin
						tick_cnt = '0;
						kind     = swarq_pkg::EV_RETX;
						fire     = 1'b1;
					end else if (it.reply_flags[swarq_pkg::INUSE_BIT]
							&& it.reply_ack == {15'd0, pkt_seq}) begin
						pend = 1'b0;
						kind = swarq_pkg::EV_DELIVER;
						fire = 1'b1;
					end
				end
			end
			swarq_pkg::CMD_TICK: begin
				if (pend) begin
					if (tick_cnt != '1)
						tick_cnt++;
					if (tick_cnt >= tmo) begin
						fire = 1'b1;
						if (retry_cnt >= lim) begin
							pend = 1'b0;
							kind = swarq_pkg::EV_GAVE_UP;
						end else begin
							retry_cnt++;
							tick_cnt = '0;
							kind     = swarq_pkg::EV_RETX;
						end
					end
				end
			end
			swarq_pkg::CMD_CLEAR_SEQ: begin
				nxt_seq = 1'b0;
			end
			default: ;
		endcase
		res = '{kind, pkt_seq, pkt_flags, pkt_csum, retry_cnt};
		return fire;
	endfunction

	function automatic arq_item_t random_item(swarq_pkg::cmd_t c);
		arq_item_t it;
		it.cmd         = c;
		it.src_addr    = $urandom;
		it.dst_addr    = $urandom;
		it.sport       = 16'($urandom);
		it.dport       = 16'($urandom);
		it.ack_no      = 16'($urandom);
		it.flags       = 7'($urandom);
		it.pkt_count   = 16'($urandom);
		it.reply_flags = 7'($urandom);
		it.reply_ack   = $urandom_range(0, 1) ? 16'($urandom_range(0, 1)) : 16'($urandom);
		return it;
	endfunction

	function automatic arq_item_t uniform_item(swarq_pkg::cmd_t c, bit ones);
		arq_item_t it;
		it.cmd         = c;
		it.src_addr    = {32{ones}};
		it.dst_addr    = {32{ones}};
		it.sport       = {16{ones}};
		it.dport       = {16{ones}};
		it.ack_no      = {16{ones}};
		it.flags       = {7{ones}};
		it.pkt_count   = {16{ones}};
		it.reply_flags = {7{ones}};
		it.reply_ack   = {16{ones}};
		return it;
	endfunction

	function automatic arq_item_t reply_item(logic [6:0] rf, logic [15:0] ra);
		arq_item_t it;
		it             = random_item(swarq_pkg::CMD_REPLY);
		it.reply_flags = rf;
		it.reply_ack   = ra;
		return it;
	endfunction

	// Present one item, hold it until accepted, then predict its result
	task automatic send_item(input arq_item_t it);
		arq_event_rec_t ev;
		bit             live;
		while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		command      <= it.cmd;
		src_address  <= it.src_addr;
		dst_address  <= it.dst_addr;
		src_port     <= it.sport;
		dst_port     <= it.dport;
		ack_field    <= it.ack_no;
		flags_in     <= it.flags;
		packet_count <= it.pkt_count;
		rx_flags     <= it.reply_flags;
		rx_ack       <= it.reply_ack;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		live = pend || it.cmd == swarq_pkg::CMD_SEND || it.cmd == swarq_pkg::CMD_CLEAR_SEQ;
		if (arq_advance(it, ev))
			predicted_events.push_back(ev);
		if (live)
			live_items++;
	endtask

	// Drop valid and wait until every predicted result has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (predicted_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Close any open packet, then drain
	task automatic quiesce();
		if (pend)
			send_item(reply_item(7'h01, {15'd0, pkt_seq}));
		wait_drained();
	endtask

	// Write a register, read it back, and mirror it in the shadow
	task automatic write_reg(input swarq_pkg::reg_idx_t idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== val)
			flag_error($sformatf("register %0d reads %h, expected %h", idx, prdata, val));
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			swarq_pkg::REG_TIMEOUT: tmo = val[15:0];
			swarq_pkg::REG_RETRY:   lim = val[7:0];
			default: ;
		endcase
	endtask

	task automatic set_limits(input logic [15:0] ticks, input logic [7:0] retries);
		quiesce();
		write_reg(swarq_pkg::REG_TIMEOUT, {16'd0, ticks});
		write_reg(swarq_pkg::REG_RETRY, {24'd0, retries});
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_item(random_item(swarq_pkg::CMD_TICK));
	endtask

	// Replies, ticks and sequence clears with nothing pending
	task automatic test_ignored_when_idle();
		send_item(reply_item(7'h01, 16'd0));
		send_item(reply_item(7'h41, 16'd0));
		send_item(random_item(swarq_pkg::CMD_TICK));
		send_item(uniform_item(swarq_pkg::CMD_CLEAR_SEQ, 1'b1));
	endtask

	// Send, busy rejection, malformed replies, NACK and ACK
	task automatic test_send_and_reply();
		send_item(uniform_item(swarq_pkg::CMD_SEND, 1'b0));
		send_item(uniform_item(swarq_pkg::CMD_SEND, 1'b1));
		send_item(reply_item(7'h00, 16'd0));
		send_item(reply_item(7'h01, 16'd1));
		send_item(reply_item(7'h01, 16'hffff));
		send_item(reply_item(7'h40, 16'd0));
		send_item(reply_item(7'h41, 16'd0));
		send_item(reply_item(7'h7f, 16'hffff));
		send_item(reply_item(7'h01, 16'd0));
	endtask

	// Clear the sequence bit while a packet is pending; the packet keeps its bit
	task automatic test_sequence_clear();
		send_item(uniform_item(swarq_pkg::CMD_SEND, 1'b1));
		send_item(uniform_item(swarq_pkg::CMD_CLEAR_SEQ, 1'b0));
		send_item(reply_item(7'h3f, 16'd1));
		send_item(random_item(swarq_pkg::CMD_SEND));
		send_item(reply_item(7'h01, 16'd0));
	endtask

	// Timeout retransmission, give-up and the register extremes
	task automatic test_timeouts();
		set_limits(16'd1, 8'd0);
		send_item(random_item(swarq_pkg::CMD_SEND));
		send_ticks(1);
		send_item(reply_item(7'h41, 16'd0));
		set_limits(16'd3, 8'd2);
		send_item(random_item(swarq_pkg::CMD_SEND));
		send_ticks(2);
		send_item(reply_item(7'h41, {15'd0, pkt_seq}));
		send_ticks(9);
		set_limits(16'd0, 8'd1);
		send_item(random_item(swarq_pkg::CMD_SEND));
		send_ticks(2);
		set_limits(16'd1, 8'd255);
		send_item(random_item(swarq_pkg::CMD_SEND));
		send_ticks(256);
		set_limits(16'hffff, 8'd255);
		send_item(random_item(swarq_pkg::CMD_SEND));
		send_ticks(40);
		send_item(reply_item(7'h01, {15'd0, pkt_seq}));
	endtask

	// One packet exchange: send, a random mix of events, then ACK or ticks
	task automatic run_exchange();
		int        r;
		arq_item_t it;
		send_item(random_item(swarq_pkg::CMD_SEND));
		repeat ($urandom_range(0, 10)) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				it = random_item(swarq_pkg::CMD_TICK);
			end else if (r < 55) begin
				it = reply_item(7'($urandom) | 7'h41, 16'($urandom));
			end else if (r < 70) begin
				if ($urandom_range(0, 1))
					it = reply_item(7'($urandom) & 7'h3e, 16'($urandom));
				else
					it = reply_item((7'($urandom) & 7'h3f) | 7'h01,
						{15'($urandom), ~pkt_seq});
			end else if (r < 80) begin
				it = random_item(swarq_pkg::CMD_SEND);
			end else if (r < 85) begin
				it = random_item(swarq_pkg::CMD_CLEAR_SEQ);
			end else begin
				it = random_item(swarq_pkg::cmd_t'($urandom_range(0, 3)));
			end
			send_item(it);
		end
		if ($urandom_range(0, 99) < 70)
			send_item(reply_item((7'($urandom) & 7'h3f) | 7'h01, {15'd0, pkt_seq}));
		else
			send_ticks($urandom_range(1, 20));
	endtask

	// Random exchanges under each idling mode and several register settings
	task automatic test_random_traffic();
		int idle_set[4]  = '{0, 47, 0, 34};
		int stall_set[4] = '{0, 0, 47, 34};
		int target;
		target = live_items;
		for (int k = 0; k < 8; k++) begin
			if (k == 0)
				set_limits(16'd1, 8'd0);
			else if (k == 2)
				set_limits(16'hffff, 8'd255);
			else if (k == 5)
				set_limits(16'($urandom_range(1, 3)), 8'd255);
			else
				set_limits(16'($urandom_range(1, 8)), 8'($urandom_range(0, 3)));
			sender_idle_pct = idle_set[k % 4];
			stall_pct       = stall_set[k % 4];
			target += 90;
			while (live_items < target) begin
				if ($urandom_range(0, 99) < 3)
					wait_drained();
				run_exchange();
			end
		end
		sender_idle_pct = 0;
		stall_pct       = 0;
	endtask

	// Drive the result stall
	always @(posedge clk)
		out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (predicted_events.size() == 0) begin
				flag_error($sformatf("unexpected result: kind %0d seq %0d flags %h csum %h retries %0d",
					event_kind, seq_bit, tx_flags, header_checksum, retries_used));
			end else begin
				want_ev = predicted_events.pop_front();
				if (event_kind !== want_ev.kind || seq_bit !== want_ev.seq
						|| tx_flags !== want_ev.flags || header_checksum !== want_ev.csum
						|| retries_used !== want_ev.retries)
					flag_error($sformatf({"result mismatch: expected kind %0d seq %0d flags %h ",
						"csum %h retries %0d, got kind %0d seq %0d flags %h csum %h retries %0d"},
						want_ev.kind, want_ev.seq, want_ev.flags, want_ev.csum, want_ev.retries,
						event_kind, seq_bit, tx_flags, header_checksum, retries_used));
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		pend      = 1'b0;
		nxt_seq   = 1'b0;
		pkt_seq   = 1'b0;
		pkt_flags = '0;
		pkt_csum  = '0;
		tick_cnt  = '0;
		retry_cnt = '0;
		sender_idle_pct = 0;
		stall_pct       = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_ignored_when_idle();
		test_send_and_reply();
		test_sequence_clear();
		test_timeouts();
		test_random_traffic();
		wait_drained();
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
